### hw/rtl/etcs_pkg.sv
`default_nettype none

package etcs_pkg;

    localparam int DIV_W     = 16;
    localparam int DIV_NUM_W = 3 * DIV_W;
    localparam int CNT_W     = $clog2(DIV_W);

    localparam logic [15:0] SAT16       = 16'hFFFF;
    localparam logic [31:0] RATIO_SCALE = 32'd1000;
    localparam logic [7:0]  NOSYNC_IDX  = 8'hFF;

    localparam logic [7:0]  TEETH_RST = 8'd24;
    localparam logic [15:0] ANGLE_RST = 16'd30;
    localparam logic [15:0] SCALE_RST = 16'd1;
    localparam logic [15:0] LATE_RST  = 16'd1500;
    localparam logic [15:0] EARLY_RST = 16'd500;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEETH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY = 3'd4;

    typedef enum logic [2:0] {
        LOSS_NONE  = 3'd0,
        LOSS_HIGH  = 3'd1,
        LOSS_LATE  = 3'd2,
        LOSS_EARLY = 3'd3,
        LOSS_LOW   = 3'd4
    } loss_reason_t;

    typedef struct packed {
        logic        kind;
        logic        pin_low;
        logic [15:0] capture_word;
        logic [15:0] extension_word;
        logic        overflow_pending;
    } in_item_t;

    typedef struct packed {
        logic         synced;
        logic [7:0]   event_index;
        logic [15:0]  ticks_per_degree;
        logic [15:0]  period_ratio;
        logic         calc_request;
        logic         schedule_pulse;
        logic         sync_lost;
        loss_reason_t loss_reason;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_sts_t;

endpackage

`default_nettype wire

### hw/rtl/etcs_div.sv
`default_nettype none

module etcs_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire etcs_pkg::div_req_t req,
    output etcs_pkg::div_sts_t    sts
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [etcs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [etcs_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [etcs_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic [etcs_pkg::DIV_W-1:0]   den_reg, den_next;

    logic [etcs_pkg::DIV_W:0]     trial;
    logic                         fits;
    logic                         sat;

    // quotient would not fit in DIV_W bits (also covers a zero divisor)
    assign sat = req.num[etcs_pkg::DIV_NUM_W-1:etcs_pkg::DIV_W]
                 >= (etcs_pkg::DIV_NUM_W - etcs_pkg::DIV_W)'(req.den);

    assign trial = {rem_reg, quo_reg[etcs_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            den_next = req.den;
            cnt_next = '0;
            if (sat)
            begin
                quo_next  = etcs_pkg::SAT16;
                done_next = 1'b1;
            end
            else
            begin
                // upper part is already below the divisor
                rem_next  = req.num[2*etcs_pkg::DIV_W-1:etcs_pkg::DIV_W];
                quo_next  = req.num[etcs_pkg::DIV_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? etcs_pkg::DIV_W'(trial - {1'b0, den_reg})
                            : trial[etcs_pkg::DIV_W-1:0];
            quo_next = {quo_reg[etcs_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + etcs_pkg::CNT_W'(1);
            if (cnt_reg == etcs_pkg::CNT_W'(etcs_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.done = done_reg;
    assign sts.quot = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) || $past(req.start)))
        else $error("divider done without a running division");

endmodule

`default_nettype wire

### hw/rtl/even_tooth_cam_sync_decoder.sv
`default_nettype none

// Crank wheel decoder for an evenly toothed primary wheel with a single-tooth
// cam sync input. One transaction on the input channel is one edge; each edge
// gives exactly one result transaction. Edges that are not low and secondary
// edges go from acceptance straight to the done step, and the next edge can
// be taken once that step has handed its result on. A primary edge with a
// valid previous stamp runs a ticks-per-degree division, unless the scale or
// the period is zero or wider than 32 bits, and, when synced with a known
// previous rate and the index not reaching the tooth count, a period ratio
// division; both go through one shared 16-step restoring divider. A primary
// edge without a previous stamp runs no division. The input stalls while an
// edge is in work; a finished result waits in the output register without
// holding off the next edge, but that edge's result waits in the done step
// for as long as the previous one is still stalled. Configuration writes are
// always taken and must only happen while idle.
module even_tooth_cam_sync_decoder #(
    parameter int STAMP_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire etcs_pkg::in_item_t                in_item,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output etcs_pkg::out_item_t                    out_result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [etcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [15:0]                       cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PERIOD = 8'b0000_0010,
        ST_TSTART = 8'b0000_0100,
        ST_TWAIT  = 8'b0000_1000,
        ST_RATIO  = 8'b0001_0000,
        ST_RSTART = 8'b0010_0000,
        ST_RWAIT  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  teeth_reg;
    logic [15:0] angle_reg, scale_reg, late_reg, early_reg;

    // decoder state
    logic                  sync_reg, sync_next;
    logic                  stamp_valid_reg, stamp_valid_next;
    logic                  period_valid_reg, period_valid_next;
    logic [7:0]            index_reg, index_next;
    logic [STAMP_BITS-1:0] last_stamp_reg, last_stamp_next;
    logic [15:0]           last_rate_reg, last_rate_next;

    // item in work
    etcs_pkg::in_item_t    item_reg, item_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [etcs_pkg::DIV_NUM_W-1:0] prod_reg, prod_next;
    logic [15:0]           ticks_reg, ticks_next;
    logic [15:0]           ratio_reg, ratio_next;

    logic                  out_valid_reg, out_valid_next;
    etcs_pkg::out_item_t   out_reg, out_next;

    logic                  accept;
    logic                  commit;
    logic [15:0]           high_word;
    logic [STAMP_BITS-1:0] period;
    logic [63:0]           period_wide;
    logic                  period_big;
    logic [15:0]           mul_a;
    logic [31:0]           mul_b;
    logic [etcs_pkg::DIV_NUM_W-1:0] mul_p;
    logic [7:0]            index_inc;
    logic                  need_ratio;

    etcs_pkg::div_req_t    div_req;
    etcs_pkg::div_sts_t    div_sts;
    etcs_pkg::out_item_t   res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // extension word runs one behind when an overflow is pending on a low capture
    assign high_word = (in_item.overflow_pending && !in_item.capture_word[15])
                       ? in_item.extension_word + 16'd1 : in_item.extension_word;

    assign period      = stamp_reg - last_stamp_reg;
    assign period_wide = 64'(period);
    assign period_big  = |period_wide[63:32];

    // one multiplier, shared by the tick scaling and the ratio scaling
    assign mul_a = (state_reg == ST_PERIOD) ? scale_reg : last_rate_reg;
    assign mul_b = (state_reg == ST_PERIOD) ? period_wide[31:0] : etcs_pkg::RATIO_SCALE;
    assign mul_p = etcs_pkg::DIV_NUM_W'(mul_a) * etcs_pkg::DIV_NUM_W'(mul_b);

    assign index_inc  = index_reg + 8'd1;
    assign need_ratio = sync_reg && period_valid_reg && (index_inc != teeth_reg);

    assign div_req.start = (state_reg == ST_TSTART) || (state_reg == ST_RSTART);
    assign div_req.num   = prod_reg;
    assign div_req.den   = (state_reg == ST_TSTART) ? angle_reg : ticks_reg;

    etcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    // result and state update of the finished edge
    always_comb
    begin
        res                   = '0;
        res.loss_reason       = etcs_pkg::LOSS_NONE;
        res.ticks_per_degree  = ticks_reg;
        res.period_ratio      = ratio_reg;
        sync_next             = sync_reg;
        stamp_valid_next      = stamp_valid_reg;
        period_valid_next     = period_valid_reg;
        index_next            = index_reg;
        last_stamp_next       = last_stamp_reg;
        last_rate_next        = last_rate_reg;
        if (item_reg.pin_low && !item_reg.kind)
        begin
            if (sync_reg)
            begin
                index_next = index_inc;
                if (index_inc == teeth_reg)
                    res.loss_reason = etcs_pkg::LOSS_HIGH;
                else if (period_valid_reg && ratio_reg > late_reg)
                    res.loss_reason = etcs_pkg::LOSS_LATE;
                else if (period_valid_reg && ratio_reg < early_reg)
                    res.loss_reason = etcs_pkg::LOSS_EARLY;
                if (res.loss_reason == etcs_pkg::LOSS_NONE)
                begin
                    res.calc_request   = stamp_valid_reg;
                    res.schedule_pulse = 1'b1;
                end
            end
            if (res.loss_reason != etcs_pkg::LOSS_NONE)
            begin
                sync_next         = 1'b0;
                stamp_valid_next  = 1'b0;
                period_valid_next = 1'b0;
            end
            else
            begin
                if (stamp_valid_reg)
                begin
                    last_rate_next    = ticks_reg;
                    period_valid_next = 1'b1;
                end
                last_stamp_next  = stamp_reg;
                stamp_valid_next = 1'b1;
            end
        end
        else if (item_reg.pin_low)
        begin
            if (sync_reg)
            begin
                // a zero tooth count would wrap to 255, so it is caught as too high here
                if (teeth_reg == 8'd0 || index_reg > teeth_reg - 8'd1)
                    res.loss_reason = etcs_pkg::LOSS_HIGH;
                else if (index_reg < teeth_reg - 8'd1)
                    res.loss_reason = etcs_pkg::LOSS_LOW;
                if (res.loss_reason != etcs_pkg::LOSS_NONE)
                begin
                    sync_next         = 1'b0;
                    stamp_valid_next  = 1'b0;
                    period_valid_next = 1'b0;
                end
            end
            else
            begin
                sync_next = 1'b1;
            end
            index_next = etcs_pkg::NOSYNC_IDX;
        end
        res.sync_lost   = (res.loss_reason != etcs_pkg::LOSS_NONE);
        res.synced      = sync_next;
        res.event_index = index_next;
    end

    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        stamp_next = stamp_reg;
        prod_next  = prod_reg;
        ticks_next = ticks_reg;
        ratio_next = ratio_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_item;
                    stamp_next = STAMP_BITS'({high_word, in_item.capture_word});
                    ticks_next = '0;
                    ratio_next = '0;
                    state_next = (in_item.pin_low && !in_item.kind) ? ST_PERIOD : ST_DONE;
                end
            end
            ST_PERIOD:
            begin
                state_next = ST_RATIO;
                if (stamp_valid_reg)
                begin
                    if (scale_reg == 16'd0 || period == '0)
                        ticks_next = '0;
                    else if (period_big)
                        ticks_next = etcs_pkg::SAT16;
                    else
                    begin
                        prod_next  = mul_p;
                        state_next = ST_TSTART;
                    end
                end
            end
            ST_TSTART:
                state_next = ST_TWAIT;
            ST_TWAIT:
            begin
                if (div_sts.done)
                begin
                    ticks_next = div_sts.quot;
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                if (need_ratio)
                begin
                    prod_next  = mul_p;
                    state_next = ST_RSTART;
                end
                else
                    state_next = ST_DONE;
            end
            ST_RSTART:
                state_next = ST_RWAIT;
            ST_RWAIT:
            begin
                if (div_sts.done)
                begin
                    ratio_next = div_sts.quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            sync_reg         <= 1'b0;
            stamp_valid_reg  <= 1'b0;
            period_valid_reg <= 1'b0;
            index_reg        <= '0;
            last_stamp_reg   <= '0;
            last_rate_reg    <= '0;
            teeth_reg        <= etcs_pkg::TEETH_RST;
            angle_reg        <= etcs_pkg::ANGLE_RST;
            scale_reg        <= etcs_pkg::SCALE_RST;
            late_reg         <= etcs_pkg::LATE_RST;
            early_reg        <= etcs_pkg::EARLY_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                sync_reg         <= sync_next;
                stamp_valid_reg  <= stamp_valid_next;
                period_valid_reg <= period_valid_next;
                index_reg        <= index_next;
                last_stamp_reg   <= last_stamp_next;
                last_rate_reg    <= last_rate_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    etcs_pkg::CFG_TEETH: teeth_reg <= cfg_data[7:0];
                    etcs_pkg::CFG_ANGLE: angle_reg <= cfg_data;
                    etcs_pkg::CFG_SCALE: scale_reg <= cfg_data;
                    etcs_pkg::CFG_LATE:  late_reg  <= cfg_data;
                    etcs_pkg::CFG_EARLY: early_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        stamp_reg <= stamp_next;
        prod_reg  <= prod_next;
        ticks_reg <= ticks_next;
        ratio_reg <= ratio_next;
        out_reg   <= out_next;
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done step");

    a_loss_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sync_lost) |-> !out_reg.synced)
        else $error("loss of sync reported while still synced");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_TWAIT || state_reg == ST_RWAIT))
        else $error("division finished with nobody waiting");

endmodule

`default_nettype wire
